// ===== rtl/spts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package spts_pkg;

   // Field widths of the channels and registers.
   localparam int TimerWidth  = 16;
   localparam int WidthBits   = 12;
   localparam int SampleBits  = 10;
   localparam int PinFieldW   = 4;
   localparam int CsrIndexW   = 3;
   localparam int CsrDataW    = 16;

   // Item kinds carried on the request tuser bit.
   localparam logic OP_TICK   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   // Register indexes on the configuration port.
   localparam logic [CsrIndexW-1:0] REG_FRAME_PERIOD = 3'd0;
   localparam logic [CsrIndexW-1:0] REG_TAIL_GAP     = 3'd1;
   localparam logic [CsrIndexW-1:0] REG_WIDTH_SECOND = 3'd2;
   localparam logic [CsrIndexW-1:0] REG_WIDTH_THIRD  = 3'd3;
   localparam logic [CsrIndexW-1:0] REG_WIDTH_FOURTH = 3'd4;
   localparam logic [CsrIndexW-1:0] REG_ARM_FRAMES   = 3'd5;
   localparam logic [CsrIndexW-1:0] REG_OUT_MIN      = 3'd6;
   localparam logic [CsrIndexW-1:0] REG_OUT_MAX      = 3'd7;

   // Reset values.
   localparam logic [TimerWidth-1:0] FRAME_PERIOD_RST = 16'd20000;
   localparam logic [WidthBits-1:0]  TAIL_GAP_RST     = 12'd500;
   localparam logic [WidthBits-1:0]  WIDTH_RST        = 12'd700;
   localparam logic [TimerWidth-1:0] ARM_FRAMES_RST   = 16'(7 * 50);
   localparam logic [WidthBits-1:0]  OUT_MIN_RST      = 12'd700;
   localparam logic [WidthBits-1:0]  OUT_MAX_RST      = 12'd1000;

   // The converter reading is clamped to 512..1023; the span below is 1023 - 512.
   localparam int AdcLow  = 512;
   localparam int AdcHigh = 1023;
   localparam int AdcSpan = AdcHigh - AdcLow;

   typedef logic [TimerWidth-1:0] timer_type;
   typedef logic [WidthBits-1:0]  width_type;

endpackage

`default_nettype wire

// ===== rtl/servo_pulse_train_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A result beat is presented from registers in the cycle after its request beat is accepted.
// One item per cycle while the result side is not stalled; all sequencing state updates in the accept cycle.
// The single result register is refilled while it is being drained.
// Reset (synchronous, active high) restores the default registers, clears the
// timer and frame count, and starts the frame with the first output high.

module servo_pulse_train_sequencer #(
   parameter int NUM_OUTPUTS = 4
) (
   input  wire         clock,
   input  wire         reset,
   // Request channel.
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,   // [9:0] sample
   input  wire  [0:0]  req_tuser,   // [0] opcode
   // Result channel.
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,   // [3:0] pin_levels, [19:4] frame_count, [31:20] first_width
   // Configuration write port.
   input  wire         csr_we,
   input  wire  [spts_pkg::CsrIndexW-1:0] csr_index,
   input  wire  [spts_pkg::CsrDataW-1:0]  csr_wdata
);

   localparam int SLOT_W = $clog2(NUM_OUTPUTS + 1);
   localparam logic [SLOT_W-1:0] SLOT_WAIT = SLOT_W'(NUM_OUTPUTS);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_OUTPUTS - 1);

   // Configuration registers.
   spts_pkg::timer_type frame_period_ff;
   spts_pkg::width_type tail_gap_ff;
   spts_pkg::width_type width_second_ff;
   spts_pkg::width_type width_third_ff;
   spts_pkg::width_type width_fourth_ff;
   spts_pkg::timer_type arm_frames_ff;
   spts_pkg::width_type out_min_ff;
   spts_pkg::width_type out_max_ff;

   // Sequencer state.
   spts_pkg::timer_type    timer_ff, timer_in;
   spts_pkg::timer_type    compare_ff, compare_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [NUM_OUTPUTS-1:0] pins_ff, pins_in;
   spts_pkg::timer_type    frames_ff, frames_in;
   spts_pkg::width_type    width_first_ff, width_first_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic                   accept;
   logic                   is_tick;
   spts_pkg::timer_type    timer_inc;
   logic [SLOT_W-1:0]      slot_next;
   spts_pkg::width_type    width_next;

   // Sample mapping signals.
   logic [8:0]             adc_x;
   logic signed [12:0]     span;
   logic                   span_neg;
   logic [11:0]            span_mag;
   logic [20:0]            prod;
   logic [12:0]            fold1;
   logic [9:0]             fold2;
   logic [11:0]            quot;
   spts_pkg::width_type    mapped;

   // A new beat is taken whenever the result register is empty or draining.
   assign accept     = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign is_tick    = (req_tuser[0] == spts_pkg::OP_TICK);
   assign timer_inc  = timer_ff + 16'd1;
   assign slot_next  = slot_ff + SLOT_W'(1);

   // Width of the pulse that starts after the current one.
   always_comb begin
      case (slot_next)
         SLOT_W'(1): width_next = width_second_ff;
         SLOT_W'(2): width_next = width_third_ff;
         default:    width_next = width_fourth_ff;
      endcase
   end

   // Map the clamped sample onto out_min..out_max. The product is divided by 511
   // in sign-magnitude form, so the quotient truncates toward zero. Using
   // 512*a + b = 511*a + (a + b) twice leaves one compare against 511.
   always_comb begin
      adc_x    = req_tdata[9] ? req_tdata[8:0] : 9'd0;
      span     = $signed({1'b0, out_max_ff}) - $signed({1'b0, out_min_ff});
      span_neg = span[12];
      span_mag = span_neg ? 12'(-span) : span[11:0];
      prod     = 21'(adc_x) * 21'(span_mag);
      fold1    = 13'(prod[20:9]) + 13'(prod[8:0]);
      fold2    = 10'(fold1[12:9]) + 10'(fold1[8:0]);
      quot     = prod[20:9] + 12'(fold1[12:9])
                 + ((fold2 >= 10'(spts_pkg::AdcSpan)) ? 12'd1 : 12'd0);
      mapped   = span_neg ? (out_min_ff - quot) : (out_min_ff + quot);
   end

   // Next state for one accepted beat.
   always_comb begin
      timer_in       = timer_ff;
      compare_in     = compare_ff;
      slot_in        = slot_ff;
      pins_in        = pins_ff;
      frames_in      = frames_ff;
      width_first_in = width_first_ff;
      if (is_tick) begin
         timer_in = timer_inc;
         if (timer_inc == compare_ff) begin
            if (slot_ff == SLOT_WAIT) begin
               // Waiting: restart the frame once the period is reached.
               if (timer_inc >= frame_period_ff) begin
                  timer_in   = '0;
                  slot_in    = '0;
                  pins_in[0] = 1'b1;
                  compare_in = 16'(width_first_ff);
                  frames_in  = frames_ff + 16'd1;
               end else begin
                  compare_in = frame_period_ff;
               end
            end else if (slot_ff != SLOT_LAST) begin
               // Hand the pulse on to the next output.
               compare_in = timer_inc + 16'(width_next);
               for (int k = 0; k < NUM_OUTPUTS; k++) begin
                  if (slot_ff == SLOT_W'(k)) begin
                     pins_in[k] = 1'b0;
                  end
                  if (k > 0 && slot_ff == SLOT_W'(k - 1)) begin
                     pins_in[k] = 1'b1;
                  end
               end
               slot_in = slot_next;
            end else begin
               // Last pulse ends; wait out the tail gap.
               pins_in[NUM_OUTPUTS-1] = 1'b0;
               compare_in = timer_inc + 16'(tail_gap_ff);
               slot_in    = SLOT_WAIT;
            end
         end
      end else if (frames_ff > arm_frames_ff) begin
         width_first_in = mapped;
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   // State and result-valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ff       <= '0;
         compare_ff     <= 16'(spts_pkg::WIDTH_RST);
         slot_ff        <= '0;
         pins_ff        <= NUM_OUTPUTS'(1);
         frames_ff      <= '0;
         width_first_ff <= spts_pkg::WIDTH_RST;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            timer_ff       <= timer_in;
            compare_ff     <= compare_in;
            slot_ff        <= slot_in;
            pins_ff        <= pins_in;
            frames_ff      <= frames_in;
            width_first_ff <= width_first_in;
         end
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_period_ff <= spts_pkg::FRAME_PERIOD_RST;
         tail_gap_ff     <= spts_pkg::TAIL_GAP_RST;
         width_second_ff <= spts_pkg::WIDTH_RST;
         width_third_ff  <= spts_pkg::WIDTH_RST;
         width_fourth_ff <= spts_pkg::WIDTH_RST;
         arm_frames_ff   <= spts_pkg::ARM_FRAMES_RST;
         out_min_ff      <= spts_pkg::OUT_MIN_RST;
         out_max_ff      <= spts_pkg::OUT_MAX_RST;
      end else if (csr_we) begin
         case (csr_index)
            spts_pkg::REG_FRAME_PERIOD: frame_period_ff <= csr_wdata;
            spts_pkg::REG_TAIL_GAP:     tail_gap_ff     <= csr_wdata[11:0];
            spts_pkg::REG_WIDTH_SECOND: width_second_ff <= csr_wdata[11:0];
            spts_pkg::REG_WIDTH_THIRD:  width_third_ff  <= csr_wdata[11:0];
            spts_pkg::REG_WIDTH_FOURTH: width_fourth_ff <= csr_wdata[11:0];
            spts_pkg::REG_ARM_FRAMES:   arm_frames_ff   <= csr_wdata;
            spts_pkg::REG_OUT_MIN:      out_min_ff      <= csr_wdata[11:0];
            spts_pkg::REG_OUT_MAX:      out_max_ff      <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   // The state registers change only on accepted beats, so they hold the
   // result of the last beat for as long as it waits on the result side.
   always_comb begin
      rsp_tdata = '0;
      for (int k = 0; k < spts_pkg::PinFieldW; k++) begin
         if (k < NUM_OUTPUTS) begin
            rsp_tdata[k] = pins_ff[k];
         end
      end
      rsp_tdata[19:4]  = frames_ff;
      rsp_tdata[31:20] = width_first_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

   localparam int NumOutputs = 4;
   // Cycles without any accepted beat before the run is declared hung.
   localparam int StallLimit = 5000;

   // One result beat, laid out as rsp_tdata: pins low, frame count, first width high.
   typedef struct packed {
      spts_pkg::width_type            first_width;
      spts_pkg::timer_type            frame_count;
      logic [spts_pkg::PinFieldW-1:0] pin_levels;
   } seq_status_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [9:0] sample
   logic [0:0]  req_tuser = '0;   // [0] opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [3:0] pin_levels, [19:4] frame_count, [31:20] first_width
   logic        csr_we = 1'b0;
   logic [spts_pkg::CsrIndexW-1:0] csr_index = '0;
   logic [spts_pkg::CsrDataW-1:0]  csr_wdata = '0;

   servo_pulse_train_sequencer #(.NUM_OUTPUTS(NumOutputs)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Predictor copy of the registers and the sequencing state.
   spts_pkg::timer_type reg_frame_period, reg_arm_frames;
   spts_pkg::width_type reg_tail_gap, reg_width_second, reg_width_third, reg_width_fourth;
   spts_pkg::width_type reg_out_min, reg_out_max;
   spts_pkg::timer_type seq_timer, seq_compare, seq_frames;
   int unsigned seq_slot;
   logic [NumOutputs-1:0] seq_pins;
   spts_pkg::width_type seq_width_first;

   seq_status_type expected_status[$];
   int unsigned send_idle_pct, recv_idle_pct;
   int unsigned failures = 0;
   int unsigned stalled_cycles = 0;

   function automatic void restore_defaults();
      reg_frame_period = spts_pkg::FRAME_PERIOD_RST;
      reg_tail_gap     = spts_pkg::TAIL_GAP_RST;
      reg_width_second = spts_pkg::WIDTH_RST;
      reg_width_third  = spts_pkg::WIDTH_RST;
      reg_width_fourth = spts_pkg::WIDTH_RST;
      reg_arm_frames   = spts_pkg::ARM_FRAMES_RST;
      reg_out_min      = spts_pkg::OUT_MIN_RST;
      reg_out_max      = spts_pkg::OUT_MAX_RST;
      seq_timer        = '0;
      seq_compare      = spts_pkg::timer_type'(spts_pkg::WIDTH_RST);
      seq_slot         = 0;
      seq_pins         = NumOutputs'(1);
      seq_frames       = '0;
      seq_width_first  = spts_pkg::WIDTH_RST;
   endfunction

   function automatic void apply_reg(logic [spts_pkg::CsrIndexW-1:0] index,
                                     logic [spts_pkg::CsrDataW-1:0] value);
      case (index)
         spts_pkg::REG_FRAME_PERIOD: reg_frame_period = value;
         spts_pkg::REG_TAIL_GAP:     reg_tail_gap     = spts_pkg::width_type'(value);
         spts_pkg::REG_WIDTH_SECOND: reg_width_second = spts_pkg::width_type'(value);
         spts_pkg::REG_WIDTH_THIRD:  reg_width_third  = spts_pkg::width_type'(value);
         spts_pkg::REG_WIDTH_FOURTH: reg_width_fourth = spts_pkg::width_type'(value);
         spts_pkg::REG_ARM_FRAMES:   reg_arm_frames   = value;
         spts_pkg::REG_OUT_MIN:      reg_out_min      = spts_pkg::width_type'(value);
         spts_pkg::REG_OUT_MAX:      reg_out_max      = spts_pkg::width_type'(value);
         default: ;
      endcase
   endfunction

   // Outputs past the fourth share the fourth width.
   function automatic spts_pkg::width_type pulse_width(int unsigned k);
      case (k)
         0: return seq_width_first;
         1: return reg_width_second;
         2: return reg_width_third;
         default: return reg_width_fourth;
      endcase
   endfunction

   // Action taken when the timer reaches the compare value.
   function automatic void handle_match();
      if (seq_slot >= NumOutputs) begin
         if (seq_timer >= reg_frame_period) begin
            seq_timer   = '0;
            seq_slot    = 0;
            seq_pins[0] = 1'b1;
            seq_compare = spts_pkg::timer_type'(seq_width_first);
            seq_frames  = seq_frames + 1'b1;
         end else begin
            seq_compare = reg_frame_period;
         end
      end else if (seq_slot + 1 < NumOutputs) begin
         seq_compare = seq_timer + spts_pkg::timer_type'(pulse_width(seq_slot + 1));
         seq_pins[seq_slot]     = 1'b0;
         seq_pins[seq_slot + 1] = 1'b1;
         seq_slot++;
      end else begin
         seq_pins[seq_slot] = 1'b0;
         seq_compare = seq_timer + spts_pkg::timer_type'(reg_tail_gap);
         seq_slot    = NumOutputs;
      end
   endfunction

   // Clamp the reading and scale it onto the output range, truncating toward zero.
   function automatic spts_pkg::width_type scaled_width(logic [9:0] sample);
      int offset, span, value;
      offset = (int'(sample) < spts_pkg::AdcLow) ? 0 : int'(sample) - spts_pkg::AdcLow;
      span   = int'(reg_out_max) - int'(reg_out_min);
      value  = offset * span / spts_pkg::AdcSpan + int'(reg_out_min);
      return spts_pkg::width_type'(value);
   endfunction

   function automatic seq_status_type advance_sequencer(logic opcode, logic [9:0] sample);
      seq_status_type status;
      if (opcode == spts_pkg::OP_TICK) begin
         seq_timer = seq_timer + 1'b1;
         if (seq_timer == seq_compare) handle_match();
      end else if (seq_frames > reg_arm_frames) begin
         seq_width_first = scaled_width(sample);
      end
      status.pin_levels  = spts_pkg::PinFieldW'(seq_pins);
      status.frame_count = seq_frames;
      status.first_width = seq_width_first;
      return status;
   endfunction

   function automatic void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
   endfunction

   // Sender: optional idle gap, then hold the beat until it is taken.
   task automatic send_item(logic opcode, logic [9:0] sample);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= opcode;
      req_tdata  <= {6'b0, sample};
      do @(posedge clock); while (!req_tready);
      expected_status.push_back(advance_sequencer(opcode, sample));
   endtask

   // Stop sending and wait for every outstanding result beat.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(logic [spts_pkg::CsrIndexW-1:0] index,
                            logic [spts_pkg::CsrDataW-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      apply_reg(index, value);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_timing(logic [15:0] period, logic [15:0] gap,
                             logic [15:0] w2, logic [15:0] w3, logic [15:0] w4);
      write_reg(spts_pkg::REG_FRAME_PERIOD, period);
      write_reg(spts_pkg::REG_TAIL_GAP, gap);
      write_reg(spts_pkg::REG_WIDTH_SECOND, w2);
      write_reg(spts_pkg::REG_WIDTH_THIRD, w3);
      write_reg(spts_pkg::REG_WIDTH_FOURTH, w4);
   endtask

   task automatic set_mapping(logic [15:0] arm, logic [15:0] lo, logic [15:0] hi);
      write_reg(spts_pkg::REG_ARM_FRAMES, arm);
      write_reg(spts_pkg::REG_OUT_MIN, lo);
      write_reg(spts_pkg::REG_OUT_MAX, hi);
   endtask

   // Tick until the predicted frame count has moved on by the given number of frames.
   task automatic tick_through_frames(int count);
      spts_pkg::timer_type target;
      int guard;
      target = seq_frames + spts_pkg::timer_type'(count);
      guard  = 0;
      while (seq_frames != target && guard < 4000) begin
         send_item(spts_pkg::OP_TICK, 10'($urandom));
         guard++;
      end
   endtask

   // Reset values: samples are ignored until enough frames have passed.
   task automatic test_defaults();
      send_item(spts_pkg::OP_TICK, 10'h000);
      send_item(spts_pkg::OP_TICK, 10'h3FF);
      send_item(spts_pkg::OP_SAMPLE, 10'd0);
      send_item(spts_pkg::OP_SAMPLE, 10'd1023);
   endtask

   // A zero frame period: the tail match already finds the timer past the period.
   task automatic test_first_frame();
      drain_results();
      set_timing(16'd0, 16'd5, 16'd2, 16'd3, 16'd4);
      set_mapping(16'd0, 16'd0, 16'd4095);
      tick_through_frames(1);
   endtask

   // Clamping at both ends, the full range, a reversed range and the arming boundary.
   task automatic test_sample_mapping();
      logic [9:0] readings[7] = '{10'd0, 10'd511, 10'd512, 10'd513, 10'd767, 10'd1022,
                                  10'd1023};
      foreach (readings[i]) send_item(spts_pkg::OP_SAMPLE, readings[i]);
      drain_results();
      set_mapping(16'd0, 16'd100, 16'd3);
      send_item(spts_pkg::OP_SAMPLE, 10'd513);
      send_item(spts_pkg::OP_SAMPLE, 10'd1000);
      send_item(spts_pkg::OP_SAMPLE, 10'd1023);
      drain_results();
      set_mapping(16'd0, 16'd4095, 16'd0);
      send_item(spts_pkg::OP_SAMPLE, 10'd700);
      drain_results();
      // Frame count equal to the arming count must not update the width.
      set_mapping(16'd1, 16'd2, 16'd40);
      send_item(spts_pkg::OP_SAMPLE, 10'd1023);
      drain_results();
      set_mapping(16'd0, 16'd2, 16'd40);
      send_item(spts_pkg::OP_SAMPLE, 10'd512);
   endtask

   // The pulses end well before the period, so the sequencer waits for the frame end.
   task automatic test_frame_wait();
      drain_results();
      set_timing(16'd740, 16'd5, 16'd1, 16'd2, 16'd3);
      tick_through_frames(1);
   endtask

   // All registers at their top values but out_max at zero, then all ones and all zeros on the data bus.
   task automatic test_register_extremes();
      drain_results();
      set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      set_mapping(16'hFFFF, 16'hFFFF, 16'h0000);
      send_item(spts_pkg::OP_SAMPLE, 10'd1023);
      send_item(spts_pkg::OP_SAMPLE, 10'd0);
   endtask

   // Short random frames with ticks and occasional converter samples.
   task automatic test_random_traffic(int items);
      logic [9:0] reading;
      drain_results();
      set_timing(16'($urandom_range(60)), 16'($urandom_range(8, 1)),
                 16'($urandom_range(6, 1)), 16'($urandom_range(6, 1)),
                 16'($urandom_range(6, 1)));
      set_mapping(16'($urandom_range(32'(seq_frames) + 3)),
                  16'($urandom_range(40, 1)), 16'($urandom_range(40, 1)));
      for (int n = 0; n < items; n++) begin
         if (n == items / 2) drain_results();
         if ($urandom_range(99) < 15) begin
            case ($urandom_range(7))
               0: reading = 10'd0;
               1: reading = 10'd1023;
               2: reading = 10'd511;
               3: reading = 10'd512;
               default: reading = 10'($urandom_range(1023));
            endcase
            send_item(spts_pkg::OP_SAMPLE, reading);
         end else begin
            send_item(spts_pkg::OP_TICK, 10'($urandom));
         end
      end
   endtask

   // A zero width leaves the compare on the current timer, so the second output
   // keeps its pulse until the timer wraps; a short run of ticks checks that the
   // pulse does not end early.
   task automatic test_zero_width();
      int guard;
      drain_results();
      set_timing(16'd40, 16'd3, 16'd0, 16'd2, 16'd2);
      tick_through_frames(1);
      guard = 0;
      while (seq_slot != 1 && guard < 1000) begin
         send_item(spts_pkg::OP_TICK, 10'($urandom));
         guard++;
      end
      repeat (24) send_item(spts_pkg::OP_TICK, 10'($urandom));
   endtask

   // Receiver back-pressure.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Compare each result beat with the oldest prediction.
   always @(posedge clock) begin
      seq_status_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_status.size() == 0) begin
            note_failure($sformatf("unexpected result beat %h", rsp_tdata));
         end else begin
            want = expected_status.pop_front();
            if (got.pin_levels !== want.pin_levels || got.frame_count !== want.frame_count ||
                got.first_width !== want.first_width) begin
               note_failure($sformatf(
                  {"mismatch: expected pins %h frames %0d width %0d, ",
                   "got pins %h frames %0d width %0d"},
                  want.pin_levels, want.frame_count, want.first_width,
                  got.pin_levels, got.frame_count, got.first_width));
            end
         end
      end
   end

   // Hang detection: too long without a beat on either channel.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles >= StallLimit) begin
         $display("** servo_pulse_train_sequencer: FAILED **");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   initial begin
      restore_defaults();
      send_idle_pct = 16;
      recv_idle_pct = 72;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_defaults();
      test_first_frame();
      test_sample_mapping();
      test_frame_wait();
      test_register_extremes();
      test_random_traffic(80);
      send_idle_pct = 72;
      recv_idle_pct = 16;
      test_random_traffic(80);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(80);
      test_zero_width();

      drain_results();
      repeat (8) @(posedge clock);
      failures += expected_status.size();
      if (failures == 0) begin
         $display("** servo_pulse_train_sequencer: PASSED **");
      end else begin
         $display("** servo_pulse_train_sequencer: FAILED **");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/spts_pkg.sv
rtl/servo_pulse_train_sequencer.sv
tb/sv/tb.sv
